// ===== rtl/fdk_pkg.sv =====
// Shared package for the 5x5 dual-kernel feature core.
// Holds widths, limits, kernel weight tables and the stage structs.
// No dependencies; every other file but fdk_ram imports it.
`timescale 1ns / 1ps

package fdk_pkg;

   // Image geometry
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int LINES      = 4;
   localparam int WIN        = 5;

   // Field widths
   localparam int PIX_W  = 8;
   localparam int COL_W  = 11;
   localparam int ROW_W  = 12;
   localparam int CFG_W  = 12;
   localparam int SUM_W  = 12;
   localparam int PART_W = 11;

   // Line memory: one word holds the same column of all four lines
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int LINE_WORD_W = LINES * PIX_W;

   // Width register limits and reset value
   localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(5);
   localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(MAX_WIDTH);
   localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(640);

   // Row counter saturation point
   localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_HEIGHT - 1);

   // Window is fully inside once both counters reach this position
   localparam int WIN_START = WIN - 1;
   // Center sits this far up and left of the incoming pixel
   localparam int CENTER_OFS = WIN / 2;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Kernel weights
   typedef logic signed [1:0] weight_type;
   localparam weight_type W_Z = 2'sb00;
   localparam weight_type W_P = 2'sb01;
   localparam weight_type W_N = 2'sb11;

   localparam weight_type KERN_X [0:WIN-1][0:WIN-1] = '{
      '{W_N, W_N, W_Z, W_P, W_P},
      '{W_N, W_N, W_Z, W_P, W_P},
      '{W_Z, W_Z, W_Z, W_Z, W_Z},
      '{W_P, W_P, W_Z, W_N, W_N},
      '{W_P, W_P, W_Z, W_N, W_N}
   };

   localparam weight_type KERN_Y [0:WIN-1][0:WIN-1] = '{
      '{W_Z, W_N, W_N, W_N, W_Z},
      '{W_P, W_Z, W_N, W_Z, W_P},
      '{W_P, W_P, W_Z, W_P, W_P},
      '{W_P, W_Z, W_N, W_Z, W_P},
      '{W_Z, W_N, W_N, W_N, W_Z}
   };

   // Request leaving the scan stage in the cycle after acceptance
   typedef struct packed {
      logic              vld;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  pixel;
      logic              fwd;
      logic              win_valid;
      logic [COL_W-1:0]  ccol;
      logic [ROW_W-1:0]  crow;
   } fdk_stage_type;

   // Sideband carried alongside the window arithmetic
   typedef struct packed {
      logic             vld;
      logic             win_valid;
      logic [COL_W-1:0] ccol;
      logic [ROW_W-1:0] crow;
   } fdk_meta_type;

   // One finished result
   typedef struct packed {
      logic signed [SUM_W-1:0] feature_x;
      logic signed [SUM_W-1:0] feature_y;
      logic                    win_valid;
      logic [COL_W-1:0]        ccol;
      logic [ROW_W-1:0]        crow;
   } fdk_rsp_type;

endpackage

// ===== rtl/five_by_five_dual_kernel_feature_core.sv =====
// Top level of the 5x5 dual-kernel feature core.
// Instantiates fdk_scan, fdk_ram, fdk_window and fdk_fifo; uses fdk_pkg.
//
// Usage:
//   req channel: one 8-bit pixel per request in raster order; req_tuser
//   marks the first pixel of a frame and restarts the row/column counters.
//   rsp channel: one result per pixel with both kernel sums, the window
//   center coordinates and the window-valid flag in rsp_tuser. Sums and
//   coordinates read zero while the 5x5 window does not lie inside the image.
//   csr channel: image width in pixels (clamped to 5..2048); write only
//   while no pixel is in flight. csr_ready is always high.
// Throughput: one pixel per clock while req_tready is high. The four lines
//   live in one line memory word per column, read and written back once per pixel.
// Path: an accepted request passes the scan stage, window and row partial
//   registers and then enters the result queue, which raises rsp_tvalid.
// Reset: counters and window clear, width returns to 640. The line memory
//   is not cleared; a new frame overwrites it before the window uses it.
// Stall: results wait in an 8-entry queue; req_tready drops once the queue
//   plus the up to three requests in flight fill it.
`timescale 1ns / 1ps

module five_by_five_dual_kernel_feature_core (
   input  logic         clock,
   input  logic         reset,
   // request: tdata = pixel[7:0]; tuser = frame_start[0]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic [0:0]   req_tuser,
   // response: tdata = feature_x[11:0], feature_y[23:12], center_col[34:24],
   //           center_row[46:35], zero[47]; tuser = window_valid[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,
   output logic [0:0]   rsp_tuser,
   // width register write
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [11:0]  csr_data
);
   import fdk_pkg::*;

   logic [CFG_W-1:0]        width_ff;
   logic                    accept;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [LINE_WORD_W-1:0]  rd_data;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [LINE_WORD_W-1:0]  wr_data;
   fdk_stage_type           stage;
   logic                    push;
   fdk_rsp_type             push_data;
   fdk_rsp_type             out_data;
   logic [1:0]              busy_cnt;
   logic [FIFO_CNT_W-1:0]   fifo_cnt;
   logic [FIFO_CNT_W:0]     occupancy;

   // Width register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         width_ff <= csr_data;
      end
   end

   // Flow control: queue entries plus requests in flight
   assign occupancy  = (FIFO_CNT_W+1)'(fifo_cnt) + (FIFO_CNT_W+1)'(stage.vld)
                       + (FIFO_CNT_W+1)'(busy_cnt);
   assign req_tready = (occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;

   fdk_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pixel       (req_tdata),
      .frame_start (req_tuser[0]),
      .width       (width_ff),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .stage_out   (stage)
   );

   fdk_ram #(
      .WIDTH (LINE_WORD_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fdk_window u_window (
      .clock    (clock),
      .reset    (reset),
      .stage_in (stage),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .push     (push),
      .rsp      (push_data),
      .busy_cnt (busy_cnt)
   );

   fdk_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data),
      .count     (fifo_cnt)
   );

   // Response packing
   assign rsp_tdata = {1'b0, out_data.crow, out_data.ccol,
                       out_data.feature_y, out_data.feature_x};
   assign rsp_tuser = out_data.win_valid;

endmodule

// ===== rtl/fdk_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module fdk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fdk_scan.sv =====
// Raster scan stage: column/row counters, line memory read issue, window
// validity and center coordinates, same-column forward detection. Uses fdk_pkg.
`timescale 1ns / 1ps

module fdk_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [fdk_pkg::PIX_W-1:0]    pixel,
   input  logic                         frame_start,
   input  logic [fdk_pkg::CFG_W-1:0]    width,
   output logic                         rd_en,
   output logic [fdk_pkg::ADDR_W-1:0]   rd_addr,
   output fdk_pkg::fdk_stage_type       stage_out
);
   import fdk_pkg::*;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   fdk_stage_type     stage_ff, stage_in;

   logic [CFG_W-1:0]  w_act;
   logic [COL_W-1:0]  col_cur;
   logic [ROW_W-1:0]  row_cur;
   logic [CFG_W-1:0]  col_ext;
   logic [COL_W-1:0]  col_clamp;
   logic              win_ok;

   // Active width, clamped into the legal range
   always_comb begin
      if (width < WIDTH_MIN) begin
         w_act = WIDTH_MIN;
      end else if (width > WIDTH_MAX) begin
         w_act = WIDTH_MAX;
      end else begin
         w_act = width;
      end
   end

   // Position of this pixel and the column it uses in the line memory
   always_comb begin
      col_cur   = frame_start ? '0 : col_ff;
      row_cur   = frame_start ? '0 : row_ff;
      col_ext   = CFG_W'(col_cur);
      col_clamp = (col_ext >= w_act) ? COL_W'(w_act - CFG_W'(1)) : col_cur;
      win_ok    = (row_cur >= ROW_W'(WIN_START)) && (col_cur >= COL_W'(WIN_START))
                  && (col_ext < w_act);
   end

   // Counter advance
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ext + CFG_W'(1) >= w_act) begin
            col_in = '0;
            row_in = (row_cur < ROW_LIMIT) ? row_cur + ROW_W'(1) : row_cur;
         end else begin
            col_in = col_cur + COL_W'(1);
            row_in = row_cur;
         end
      end
   end

   // Request for the next stage; fwd flags a read of the column the
   // previous request writes back in this same cycle
   always_comb begin
      stage_in.vld       = 1'b1;
      stage_in.addr      = ADDR_W'(col_clamp);
      stage_in.pixel     = pixel;
      stage_in.fwd       = stage_ff.vld && (stage_ff.addr == ADDR_W'(col_clamp));
      stage_in.win_valid = win_ok;
      stage_in.ccol      = win_ok ? col_cur - COL_W'(CENTER_OFS) : '0;
      stage_in.crow      = win_ok ? row_cur - ROW_W'(CENTER_OFS) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         stage_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            stage_ff <= stage_in;
         end else begin
            stage_ff.vld <= 1'b0;
         end
      end
   end

   assign rd_en     = accept;
   assign rd_addr   = ADDR_W'(col_clamp);
   assign stage_out = stage_ff;

endmodule

// ===== rtl/fdk_window.sv =====
// Line memory write-back, 5x5 window register and the two kernel sums.
// Two register stages: window, row partials; the final sum feeds the queue. Uses fdk_pkg.
`timescale 1ns / 1ps

module fdk_window (
   input  logic                              clock,
   input  logic                              reset,
   input  fdk_pkg::fdk_stage_type            stage_in,
   input  logic [fdk_pkg::LINE_WORD_W-1:0]   rd_data,
   output logic                              wr_en,
   output logic [fdk_pkg::ADDR_W-1:0]        wr_addr,
   output logic [fdk_pkg::LINE_WORD_W-1:0]   wr_data,
   output logic                              push,
   output fdk_pkg::fdk_rsp_type              rsp,
   output logic [1:0]                        busy_cnt
);
   import fdk_pkg::*;

   logic [LINE_WORD_W-1:0]   fwd_word_ff;
   logic [LINE_WORD_W-1:0]   line_word;
   logic [PIX_W-1:0]         col_vals [0:WIN-1];
   logic [PIX_W-1:0]         window_ff [0:WIN-1][0:WIN-1];
   fdk_meta_type             meta2_ff, meta3_ff;
   logic signed [PART_W-1:0] part_x_in [0:WIN-1];
   logic signed [PART_W-1:0] part_y_in [0:WIN-1];
   logic signed [PART_W-1:0] part_x_ff [0:WIN-1];
   logic signed [PART_W-1:0] part_y_ff [0:WIN-1];
   logic signed [SUM_W-1:0]  sum_x, sum_y;

   // Column read from the line memory, or the word the previous request wrote back
   assign line_word = stage_in.fwd ? fwd_word_ff : rd_data;

   // Lines shift down by one; the new pixel becomes the newest line
   assign wr_en   = stage_in.vld;
   assign wr_addr = stage_in.addr;
   assign wr_data = {line_word[LINE_WORD_W-PIX_W-1:0], stage_in.pixel};

   // New window column, oldest line on top
   always_comb begin
      for (int i = 0; i < LINES; i++) begin
         col_vals[LINES-1-i] = line_word[i*PIX_W +: PIX_W];
      end
      col_vals[WIN-1] = stage_in.pixel;
   end

   always_ff @(posedge clock) begin
      if (stage_in.vld) begin
         fwd_word_ff <= wr_data;
      end
   end

   // Window shifts left and takes the new column on the right
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '{default: '0};
      end else if (stage_in.vld) begin
         for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN-1; c++) begin
               window_ff[r][c] <= window_ff[r][c+1];
            end
            window_ff[r][WIN-1] <= col_vals[r];
         end
      end
   end

   // Per-row partial sums for both kernels
   always_comb begin
      for (int r = 0; r < WIN; r++) begin
         part_x_in[r] = '0;
         part_y_in[r] = '0;
         for (int c = 0; c < WIN; c++) begin
            case (KERN_X[r][c])
               W_P:     part_x_in[r] = part_x_in[r] + $signed(PART_W'(window_ff[r][c]));
               W_N:     part_x_in[r] = part_x_in[r] - $signed(PART_W'(window_ff[r][c]));
               default: part_x_in[r] = part_x_in[r];
            endcase
            case (KERN_Y[r][c])
               W_P:     part_y_in[r] = part_y_in[r] + $signed(PART_W'(window_ff[r][c]));
               W_N:     part_y_in[r] = part_y_in[r] - $signed(PART_W'(window_ff[r][c]));
               default: part_y_in[r] = part_y_in[r];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      part_x_ff <= part_x_in;
      part_y_ff <= part_y_in;
   end

   // Sideband pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         meta2_ff <= '0;
         meta3_ff <= '0;
      end else begin
         meta2_ff.vld       <= stage_in.vld;
         meta2_ff.win_valid <= stage_in.win_valid;
         meta2_ff.ccol      <= stage_in.ccol;
         meta2_ff.crow      <= stage_in.crow;
         meta3_ff           <= meta2_ff;
      end
   end

   // Final sums over the five rows
   always_comb begin
      sum_x = '0;
      sum_y = '0;
      for (int r = 0; r < WIN; r++) begin
         sum_x = sum_x + SUM_W'(part_x_ff[r]);
         sum_y = sum_y + SUM_W'(part_y_ff[r]);
      end
   end

   assign push          = meta3_ff.vld;
   assign rsp.feature_x = meta3_ff.win_valid ? sum_x : '0;
   assign rsp.feature_y = meta3_ff.win_valid ? sum_y : '0;
   assign rsp.win_valid = meta3_ff.win_valid;
   assign rsp.ccol      = meta3_ff.ccol;
   assign rsp.crow      = meta3_ff.crow;

   assign busy_cnt = {1'b0, meta2_ff.vld} + {1'b0, meta3_ff.vld};

endmodule

// ===== rtl/fdk_fifo.sv =====
// Result queue between the arithmetic pipeline and the result channel.
// Register-based, FIFO_DEPTH entries. Uses fdk_pkg.
`timescale 1ns / 1ps

module fdk_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  fdk_pkg::fdk_rsp_type            push_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output fdk_pkg::fdk_rsp_type            out_data,
   output logic [fdk_pkg::FIFO_CNT_W-1:0]  count
);
   import fdk_pkg::*;

   fdk_rsp_type             mem_ff [0:FIFO_DEPTH-1];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_data = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule
